/* sv/hdtm_pkg.sv */
// Shared types and constants for the HPACK dynamic table manager.
// Used by the sequencer, shared ALU, top level and port checker.
package hdtm_pkg;

  localparam int LEN_W               = 13;
  localparam int HANDLE_W            = 32;
  localparam int ID_W                = 32;
  localparam int IDX_W               = 8;
  localparam int CNT_OUT_W           = 8;
  // name + value + overhead for any 13-bit lengths fits in 15 bits
  localparam int COST_W              = 15;
  localparam int ENTRY_OVERHEAD      = 32;
  localparam int DEF_MAX_TABLE_BYTES = 4096;
  localparam int DEF_ENTRY_DEPTH     = 128;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_RESIZE = 2'd1,
    OP_LOOKUP = 2'd2,
    OP_NONE   = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    STATUS_OK         = 2'd0,
    STATUS_TOO_LARGE  = 2'd1,
    STATUS_BAD_INDEX  = 2'd2,
    STATUS_LIMIT_HIGH = 2'd3
  } status_t;

  typedef enum logic {
    ALU_ADD = 1'b0,
    ALU_SUB = 1'b1
  } alu_op_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_COST_A,
    ST_COST_B,
    ST_FIT,
    ST_LIMIT,
    ST_EV_TEST,
    ST_EV_DROP,
    ST_INSERT,
    ST_IDX,
    ST_LK_SUB,
    ST_LK_WRAP,
    ST_LK_READ,
    ST_LK_DATA,
    ST_RESP
  } state_t;

  typedef struct packed {
    logic [1:0]          operation;
    logic [LEN_W-1:0]    name_length;
    logic [LEN_W-1:0]    value_length;
    logic [HANDLE_W-1:0] entry_handle;
    logic [IDX_W-1:0]    lookup_index;
    logic [LEN_W-1:0]    new_limit;
  } in_item_t;

  typedef struct packed {
    logic [1:0]           status;
    logic [CNT_OUT_W-1:0] evicted_count;
    logic [HANDLE_W-1:0]  found_handle;
    logic [LEN_W-1:0]     found_name_length;
    logic [LEN_W-1:0]     found_value_length;
    logic [ID_W-1:0]      found_insert_id;
    logic [CNT_OUT_W-1:0] entries_held;
    logic [LEN_W-1:0]     bytes_held;
  } result_t;

  // one ring slot as held in the descriptor RAM
  typedef struct packed {
    logic [HANDLE_W-1:0] handle;
    logic [LEN_W-1:0]    name_len;
    logic [LEN_W-1:0]    value_len;
    logic [ID_W-1:0]     insert_id;
    logic [COST_W-1:0]   cost;
  } entry_t;

endpackage

/* sv/hpack_dynamic_table_manager.sv */
// Insert: cost, fit check, evictions, write, response (no write if oversized). Resize:
// limit check, evictions, response (none if over the maximum). Lookup: index check, slot
// arithmetic, RAM read, response (only the check on a bad index). Unused: response only.
// One item at a time, busy high until done. Evict: compare, RAM read, subtract on the ALU.
// Reset (rst, synchronous) empties the table and sets the limit to MAX_TABLE_BYTES;
// RAM contents are not cleared. done is a one-cycle strobe the receiver cannot stall.
module hpack_dynamic_table_manager import hdtm_pkg::*; #(
  parameter int MAX_TABLE_BYTES = DEF_MAX_TABLE_BYTES,
  parameter int ENTRY_DEPTH     = DEF_ENTRY_DEPTH
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     start,
  input  in_item_t item,
  output logic     busy,
  output logic     done,
  output result_t  result
);

  localparam int SLOT_W = $clog2(ENTRY_DEPTH);
  localparam int LIM_W  = $clog2(MAX_TABLE_BYTES + 1);
  localparam int ACC_W  = ((LIM_W > COST_W) ? LIM_W : COST_W) + 1;

  alu_op_t           alu_op;
  logic [ACC_W-1:0]  alu_a, alu_b, alu_y;
  logic              alu_borrow;
  logic              ram_we;
  logic [SLOT_W-1:0] ram_waddr, ram_raddr;
  entry_t            ram_wdata, ram_rdata;

  hdtm_seq #(
    .MAX_TABLE_BYTES(MAX_TABLE_BYTES),
    .ENTRY_DEPTH    (ENTRY_DEPTH)
  ) u_seq (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .item      (item),
    .busy      (busy),
    .done      (done),
    .result    (result),
    .alu_op    (alu_op),
    .alu_a     (alu_a),
    .alu_b     (alu_b),
    .alu_y     (alu_y),
    .alu_borrow(alu_borrow),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata)
  );

  hdtm_alu #(
    .W(ACC_W)
  ) u_alu (
    .op    (alu_op),
    .a     (alu_a),
    .b     (alu_b),
    .y     (alu_y),
    .borrow(alu_borrow)
  );

  hdtm_ram #(
    .WIDTH($bits(entry_t)),
    .DEPTH(ENTRY_DEPTH)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

endmodule

/* sv/hdtm_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module hdtm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* sv/hdtm_alu.sv */
// Shared add/subtract unit with borrow flag for the table sequencer.
// Depends on hdtm_pkg for the operation code.
module hdtm_alu import hdtm_pkg::*; #(
  parameter int W = 16
) (
  input  alu_op_t      op,
  input  logic [W-1:0] a,
  input  logic [W-1:0] b,
  output logic [W-1:0] y,
  output logic         borrow
);

  logic [W:0] wide;

  always_comb begin
    case (op)
      ALU_ADD: wide = {1'b0, a} + {1'b0, b};
      ALU_SUB: wide = {1'b0, a} - {1'b0, b};
      default: wide = '0;
    endcase
    y = wide[W-1:0];
    // set when a < b on a subtract
    borrow = (op == ALU_SUB) ? wide[W] : 1'b0;
  end

endmodule

/* sv/hdtm_seq.sv */
// Sequencer and table state for the HPACK dynamic table manager.
// Drives the shared ALU and the descriptor RAM; depends on hdtm_pkg.
module hdtm_seq import hdtm_pkg::*; #(
  parameter int MAX_TABLE_BYTES = DEF_MAX_TABLE_BYTES,
  parameter int ENTRY_DEPTH     = DEF_ENTRY_DEPTH,
  localparam int SLOT_W = $clog2(ENTRY_DEPTH),
  localparam int LIM_W  = $clog2(MAX_TABLE_BYTES + 1),
  localparam int ACC_W  = ((LIM_W > COST_W) ? LIM_W : COST_W) + 1
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  in_item_t          item,
  output logic              busy,
  output logic              done,
  output result_t           result,
  output alu_op_t           alu_op,
  output logic [ACC_W-1:0]  alu_a,
  output logic [ACC_W-1:0]  alu_b,
  input  logic [ACC_W-1:0]  alu_y,
  input  logic              alu_borrow,
  output logic              ram_we,
  output logic [SLOT_W-1:0] ram_waddr,
  output entry_t            ram_wdata,
  output logic [SLOT_W-1:0] ram_raddr,
  input  entry_t            ram_rdata
);

  localparam int CNT_W = $clog2(ENTRY_DEPTH + 1);

  state_t             state, state_next;
  in_item_t           item_r;
  logic [SLOT_W-1:0]  newest_slot, oldest_slot, lk_slot;
  logic [CNT_W-1:0]   entry_count, evicted;
  logic [LIM_W-1:0]   used_bytes, size_limit, target;
  logic [ID_W-1:0]    next_id;
  logic [ACC_W-1:0]   tmp;
  logic [COST_W-1:0]  cost;
  logic               oversize, wrap;
  logic [1:0]         status;
  logic [HANDLE_W-1:0] f_handle;
  logic [LEN_W-1:0]   f_name, f_value;
  logic [ID_W-1:0]    f_id;
  logic               is_insert, force_full, evict_go, idx_bad;

  function automatic logic [SLOT_W-1:0] slot_inc(input logic [SLOT_W-1:0] s);
    return (s == SLOT_W'(ENTRY_DEPTH - 1)) ? '0 : s + SLOT_W'(1);
  endfunction

  assign is_insert  = (op_t'(item_r.operation) == OP_INSERT);
  // a full ring drops one more so the insert always has a slot
  assign force_full = is_insert && !oversize && (entry_count == CNT_W'(ENTRY_DEPTH));
  assign evict_go   = (entry_count != '0) && (alu_borrow || force_full);
  assign idx_bad    = (item_r.lookup_index == '0) || alu_borrow;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    alu_op     = ALU_SUB;
    alu_a      = '0;
    alu_b      = '0;
    ram_raddr  = oldest_slot;
    case (state)
      ST_IDLE: begin
        if (start) begin
          case (op_t'(item.operation))
            OP_INSERT: state_next = ST_COST_A;
            OP_RESIZE: state_next = ST_LIMIT;
            OP_LOOKUP: state_next = ST_IDX;
            default:   state_next = ST_RESP;
          endcase
        end
      end
      ST_COST_A: begin
        alu_op     = ALU_ADD;
        alu_a      = ACC_W'(item_r.name_length);
        alu_b      = ACC_W'(item_r.value_length);
        state_next = ST_COST_B;
      end
      ST_COST_B: begin
        alu_op     = ALU_ADD;
        alu_a      = tmp;
        alu_b      = ACC_W'(ENTRY_OVERHEAD);
        state_next = ST_FIT;
      end
      ST_FIT: begin
        alu_a      = ACC_W'(size_limit);
        alu_b      = ACC_W'(cost);
        state_next = ST_EV_TEST;
      end
      ST_LIMIT: begin
        alu_a      = ACC_W'(MAX_TABLE_BYTES);
        alu_b      = ACC_W'(item_r.new_limit);
        state_next = alu_borrow ? ST_RESP : ST_EV_TEST;
      end
      ST_EV_TEST: begin
        // borrow means used_bytes > target; RAM read of the oldest slot goes out now
        alu_a = ACC_W'(target);
        alu_b = ACC_W'(used_bytes);
        if (evict_go) begin
          state_next = ST_EV_DROP;
        end else if (is_insert && !oversize) begin
          state_next = ST_INSERT;
        end else begin
          state_next = ST_RESP;
        end
      end
      ST_EV_DROP: begin
        alu_a      = ACC_W'(used_bytes);
        alu_b      = ACC_W'(ram_rdata.cost);
        state_next = ST_EV_TEST;
      end
      ST_INSERT: begin
        alu_op     = ALU_ADD;
        alu_a      = ACC_W'(used_bytes);
        alu_b      = ACC_W'(cost);
        state_next = ST_RESP;
      end
      ST_IDX: begin
        alu_a      = ACC_W'(entry_count);
        alu_b      = ACC_W'(item_r.lookup_index);
        state_next = idx_bad ? ST_RESP : ST_LK_SUB;
      end
      ST_LK_SUB: begin
        // newest + 1 - index, may go negative
        alu_a      = ACC_W'(newest_slot) + ACC_W'(1);
        alu_b      = ACC_W'(item_r.lookup_index);
        state_next = ST_LK_WRAP;
      end
      ST_LK_WRAP: begin
        alu_op     = ALU_ADD;
        alu_a      = tmp;
        alu_b      = wrap ? ACC_W'(ENTRY_DEPTH) : '0;
        state_next = ST_LK_READ;
      end
      ST_LK_READ: begin
        ram_raddr  = lk_slot;
        state_next = ST_LK_DATA;
      end
      ST_LK_DATA: state_next = ST_RESP;
      ST_RESP:    state_next = ST_IDLE;
      default:    state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      newest_slot <= '0;
      oldest_slot <= '0;
      entry_count <= '0;
      used_bytes  <= '0;
      size_limit  <= LIM_W'(MAX_TABLE_BYTES);
      next_id     <= '0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (start) begin
            item_r   <= item;
            status   <= STATUS_OK;
            evicted  <= '0;
            oversize <= 1'b0;
            f_handle <= '0;
            f_name   <= '0;
            f_value  <= '0;
            f_id     <= '0;
          end
        end
        ST_COST_A: tmp  <= alu_y;
        ST_COST_B: cost <= COST_W'(alu_y);
        ST_FIT: begin
          if (alu_borrow) begin
            oversize <= 1'b1;
            target   <= '0;
          end else begin
            target <= LIM_W'(alu_y);
          end
        end
        ST_LIMIT: begin
          if (alu_borrow) begin
            status <= STATUS_LIMIT_HIGH;
          end else begin
            target <= LIM_W'(ACC_W'(item_r.new_limit));
          end
        end
        ST_EV_TEST: begin
          if (entry_count == '0) begin
            used_bytes <= '0;
          end
          if (!evict_go) begin
            if (oversize) begin
              status <= STATUS_TOO_LARGE;
            end else if (op_t'(item_r.operation) == OP_RESIZE) begin
              size_limit <= target;
            end
          end
        end
        ST_EV_DROP: begin
          used_bytes  <= alu_borrow ? '0 : LIM_W'(alu_y);
          entry_count <= entry_count - CNT_W'(1);
          oldest_slot <= slot_inc(oldest_slot);
          evicted     <= evicted + CNT_W'(1);
        end
        ST_INSERT: begin
          used_bytes  <= LIM_W'(alu_y);
          newest_slot <= slot_inc(newest_slot);
          if (entry_count == '0) begin
            oldest_slot <= slot_inc(newest_slot);
          end
          entry_count <= entry_count + CNT_W'(1);
          f_id        <= next_id;
          next_id     <= next_id + ID_W'(1);
        end
        ST_IDX: begin
          if (idx_bad) begin
            status <= STATUS_BAD_INDEX;
          end
        end
        ST_LK_SUB: begin
          tmp  <= alu_y;
          wrap <= alu_borrow;
        end
        ST_LK_WRAP: lk_slot <= SLOT_W'(alu_y);
        ST_LK_DATA: begin
          f_handle <= ram_rdata.handle;
          f_name   <= ram_rdata.name_len;
          f_value  <= ram_rdata.value_len;
          f_id     <= ram_rdata.insert_id;
        end
        default: ;
      endcase
    end
  end

  assign ram_we              = (state == ST_INSERT);
  assign ram_waddr           = slot_inc(newest_slot);
  assign ram_wdata.handle    = item_r.entry_handle;
  assign ram_wdata.name_len  = item_r.name_length;
  assign ram_wdata.value_len = item_r.value_length;
  assign ram_wdata.insert_id = next_id;
  assign ram_wdata.cost      = cost;

  assign busy = (state != ST_IDLE);
  assign done = (state == ST_RESP);

  assign result.status             = status;
  assign result.evicted_count      = CNT_OUT_W'(evicted);
  assign result.found_handle       = f_handle;
  assign result.found_name_length  = f_name;
  assign result.found_value_length = f_value;
  assign result.found_insert_id    = f_id;
  assign result.entries_held       = CNT_OUT_W'(entry_count);
  assign result.bytes_held         = LEN_W'(ACC_W'(used_bytes));

endmodule

/* sv/hdtm_checker.sv */
// Port-level checks for the HPACK dynamic table manager, bound to the top level.
// Depends on hdtm_pkg.
module hdtm_checker import hdtm_pkg::*; (
  input logic     clk,
  input logic     rst,
  input logic     start,
  input logic     busy,
  input logic     done,
  input result_t  result
);

  // an accepted item makes the block busy
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy)
    else $error("block not busy after accepting an item");

  a_done_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> busy)
    else $error("result strobe while idle");

  // one result per item, then back to idle
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |=> !busy && !done)
    else $error("block did not return to idle after its result");

  a_too_large_empty: assert property (@(posedge clk) disable iff (rst)
    done && (result.status == STATUS_TOO_LARGE) |->
      (result.entries_held == '0) && (result.bytes_held == '0))
    else $error("oversized insert left entries in the table");

  a_no_evict_lookup: assert property (@(posedge clk) disable iff (rst)
    done && ((result.status == STATUS_BAD_INDEX) || (result.status == STATUS_LIMIT_HIGH))
      |-> (result.evicted_count == '0))
    else $error("rejected item evicted entries");

endmodule

bind hpack_dynamic_table_manager hdtm_checker u_hdtm_checker (
  .clk   (clk),
  .rst   (rst),
  .start (start),
  .busy  (busy),
  .done  (done),
  .result(result)
);
